@@ hw/rtl/qib_pkg.sv @@
package qib_pkg;

    // Width of the raw level field: lines at or above this index always read low.
    localparam int QIB_IN_W      = 4;
    localparam int QIB_CNT_W     = 16;
    localparam int QIB_NUM_LINES = 4;
    localparam int QIB_CFG_IDX_W = 2;

    localparam logic [QIB_CNT_W-1:0] QIB_ON_DELAY_RST  = 16'd1800;
    localparam logic [QIB_CNT_W-1:0] QIB_OFF_DELAY_RST = 16'd3000;

    typedef enum logic [QIB_CFG_IDX_W-1:0] {
        CFG_ON_DELAY  = 2'd0,
        CFG_OFF_DELAY = 2'd1
    } t_cfg_idx;

    // Qualification summary of one tick, handed from the line array to the controller.
    typedef struct packed {
        logic                any;
        logic [QIB_IN_W-1:0] qmask;
    } t_qual_status;

    // Event raised by the controller for the tick being processed.
    typedef struct packed {
        logic valid;
        logic level;
    } t_boost_event;

endpackage

@@ hw/rtl/qib_if.sv @@
interface qib_in_if import qib_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [QIB_IN_W-1:0] raw_levels;

    modport source (output valid, output raw_levels, input ready);
    modport sink (input valid, input raw_levels, output ready);
endinterface

interface qib_out_if import qib_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                boost_level;
    logic [QIB_IN_W-1:0] qualified_lines;

    modport source (output valid, output boost_level, output qualified_lines, input ready);
    modport sink (input valid, input boost_level, input qualified_lines, output ready);
endinterface

interface qib_cfg_if import qib_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [QIB_CFG_IDX_W-1:0] index;
    logic [QIB_CNT_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/qib_line.sv @@
module qib_line
    import qib_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_level,
    input  logic [QIB_CNT_W-1:0] i_on_delay,
    output logic                 o_qual_next
);

    logic [QIB_CNT_W-1:0] r_count;
    logic [QIB_CNT_W-1:0] n_count;
    logic                 r_qual;
    logic                 n_qual;
    logic [QIB_CNT_W:0]   w_limit_wide;
    logic [QIB_CNT_W-1:0] w_limit;

    // The count stops one above the on-delay, or at full scale.
    assign w_limit_wide = {1'b0, i_on_delay} + {{QIB_CNT_W{1'b0}}, 1'b1};
    assign w_limit      = w_limit_wide[QIB_CNT_W] ? {QIB_CNT_W{1'b1}}
                                                  : w_limit_wide[QIB_CNT_W-1:0];

    always_comb begin
        if (!i_level) begin
            n_count = '0;
        end else if (r_count < w_limit) begin
            n_count = r_count + 1'b1;
        end else begin
            n_count = r_count;
        end
        // Once qualified, a line stays so while it remains high.
        n_qual = i_level && (r_qual || (n_count > i_on_delay));
    end

    assign o_qual_next = n_qual;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_qual  <= 1'b0;
        end else if (i_en) begin
            r_count <= n_count;
            r_qual  <= n_qual;
        end
    end

endmodule

@@ hw/rtl/qib_ctrl.sv @@
module qib_ctrl
    import qib_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  t_qual_status         i_status,
    input  logic [QIB_CNT_W-1:0] i_off_delay,
    output t_boost_event         o_event,
    output logic                 o_boost_on,
    output logic [QIB_CNT_W-1:0] o_countdown
);

    logic                 r_boost_on;
    logic                 n_boost_on;
    logic [QIB_CNT_W-1:0] r_countdown;
    logic [QIB_CNT_W-1:0] n_countdown;
    logic [QIB_CNT_W-1:0] w_load;

    // A zero off-delay behaves as one tick.
    assign w_load = (i_off_delay == '0) ? {{(QIB_CNT_W-1){1'b0}}, 1'b1} : i_off_delay;

    always_comb begin
        n_boost_on    = r_boost_on;
        n_countdown   = r_countdown;
        o_event.valid = 1'b0;
        o_event.level = 1'b0;
        if (i_status.any && !r_boost_on) begin
            n_boost_on    = 1'b1;
            n_countdown   = '0;
            o_event.valid = 1'b1;
            o_event.level = 1'b1;
        end else if (!i_status.any && r_boost_on) begin
            // Release tick: load and count this tick at once.
            n_boost_on    = 1'b0;
            n_countdown   = w_load - 1'b1;
            o_event.valid = (w_load == {{(QIB_CNT_W-1){1'b0}}, 1'b1});
        end else if (!r_boost_on && (r_countdown != '0)) begin
            n_countdown   = r_countdown - 1'b1;
            o_event.valid = (r_countdown == {{(QIB_CNT_W-1){1'b0}}, 1'b1});
        end
    end

    assign o_boost_on  = r_boost_on;
    assign o_countdown = r_countdown;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boost_on  <= 1'b0;
            r_countdown <= '0;
        end else if (i_en) begin
            r_boost_on  <= n_boost_on;
            r_countdown <= n_countdown;
        end
    end

endmodule

@@ hw/rtl/qualified_input_boost_timer.sv @@
// Qualified input boost timer. Each input request is one sample tick with the raw levels
// of four lines. A line qualifies after it has stayed high for more than on_delay_ticks
// ticks and drops out at once on a low. When the first line qualifies, boost switches on
// and an on request (boost_level = 1) is sent; when no line is qualified any more, an
// off countdown of off_delay_ticks ticks starts, the release tick included, and an off
// request (boost_level = 0) is sent on the tick it runs out. A line qualifying again
// during the countdown switches boost back on, with a fresh on request and no off
// request. Ticks that change nothing produce no output request. Throughput is one tick
// per clock cycle while the output does not stall: a tick is captured in an input
// register, processed by the per-line counters and the boost controller when it advances,
// and any result lands in an output register. The output
// register is the only point of back pressure: while it holds a result that the sink has
// not taken, the tick in the input register waits, and the input side stalls once that
// register is occupied as well. Configuration writes are always taken at once; index 0
// is on_delay_ticks, index 1 is off_delay_ticks, and other indices are ignored. They
// should only be issued while no tick is in flight.
module qualified_input_boost_timer
    import qib_pkg::*;
#(
    parameter int NUM_LINES = QIB_NUM_LINES
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    qib_in_if.sink    i_in,
    qib_cfg_if.sink   i_cfg,
    qib_out_if.source o_out
);

    // Configuration registers.
    logic [QIB_CNT_W-1:0] r_on_delay;
    logic [QIB_CNT_W-1:0] r_off_delay;

    // Input stage.
    logic                r_in_valid;
    logic [QIB_IN_W-1:0] r_in_levels;

    // Result stage.
    logic                r_out_valid;
    logic                r_out_level;
    logic [QIB_IN_W-1:0] r_out_qmask;

    logic                          w_advance;
    logic [NUM_LINES-1:0]          w_qual_next;
    logic [NUM_LINES+QIB_IN_W-1:0] w_qual_pad;
    t_qual_status                  w_status;
    t_boost_event                  w_event;
    logic                          w_boost_on;
    logic [QIB_CNT_W-1:0]          w_countdown;

    // The tick in the input register moves on when the result register can take its result.
    assign w_advance   = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_advance;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_delay  <= QIB_ON_DELAY_RST;
            r_off_delay <= QIB_OFF_DELAY_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_ON_DELAY:  r_on_delay  <= i_cfg.data;
                CFG_OFF_DELAY: r_off_delay <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_levels <= i_in.raw_levels;
        end
    end

    // One counter per line. Lines beyond the width of the level field always see a low.
    genvar g;
    generate
        for (g = 0; g < NUM_LINES; g++) begin : g_line
            logic w_level;
            if (g < QIB_IN_W) begin : g_wired
                assign w_level = r_in_levels[g];
            end else begin : g_unwired
                assign w_level = 1'b0;
            end
            qib_line u_line (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_en        (w_advance),
                .i_level     (w_level),
                .i_on_delay  (r_on_delay),
                .o_qual_next (w_qual_next[g])
            );
        end
    endgenerate

    // Only lines within the level field show up in the reported mask.
    assign w_qual_pad     = {{QIB_IN_W{1'b0}}, w_qual_next};
    assign w_status.any   = |w_qual_next;
    assign w_status.qmask = w_qual_pad[QIB_IN_W-1:0];

    qib_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_advance),
        .i_status    (w_status),
        .i_off_delay (r_off_delay),
        .o_event     (w_event),
        .o_boost_on  (w_boost_on),
        .o_countdown (w_countdown)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_event.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_event.valid) begin
            r_out_level <= w_event.level;
            r_out_qmask <= w_status.qmask;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.boost_level     = r_out_level;
    assign o_out.qualified_lines = r_out_qmask;

    // The off countdown only runs while boost is off.
    a_countdown_idle_when_on : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_boost_on |-> (w_countdown == '0))
        else $error("off countdown running while boost is on");

    // An on event always reports at least one qualified line.
    a_on_has_line : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_event.valid && w_event.level) |-> (w_status.qmask != '0))
        else $error("on event with no qualified line");

    // An off event only happens with every line released.
    a_off_no_line : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_event.valid && !w_event.level) |-> !w_status.any)
        else $error("off event while a line is qualified");

    // A result is written only when the result register is free or being drained.
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> ($stable(r_out_level) && $stable(r_out_qmask)))
        else $error("stalled result overwritten");

endmodule
